// ----- design/kws_pkg.sv -----
// kws_pkg: types and fixed constants of the k-mer weight sequence scorer
// no dependencies; imported by kmer_weight_sequence_scorer

package kws_pkg;

  localparam int WEIGHT_W = 16;
  localparam int ENTRY_W  = WEIGHT_W + 1;
  localparam int COUNT_W  = 20;
  localparam int STATUS_W = 3;
  localparam int KLEN_W   = 4;
  localparam int INDEX_W  = 16;
  localparam int CHAR_W   = 8;

  localparam logic [KLEN_W-1:0] KLEN_RESET = 4'd8;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_BASE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_SHORT    = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_BASE = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_ABSENT   = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 3'd4;

  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH,
    ST_DIVIDE
  } state_t;

endpackage

// ----- design/kmer_weight_sequence_scorer.sv -----
// kmer_weight_sequence_scorer: k-mer weight table, base stream scoring, mean divider
// depends on kws_pkg
//
//   channel   handshake                    payload
//   item      item_valid / item_stall      cmd entry_index entry_weight entry_present
//                                          base_char last_base
//   result    result_valid / result_stall  mean_score window_count status
//   config    cfg_wr_en                    cfg_wr_data (kmer_length)
//
// table writes and bases are taken one per cycle while item_stall is low; a base's
// two lookups (forward and reverse complement) read the table memory at accept and
// are summed in the cycle after; the last base of a sequence holds the input through
// the drain and finish states, plus the shift-subtract divider when the status is ok
// after reset a clearing pass writes all 4**MAX_K table entries, one per cycle, before
// the first item is taken; a stalled result stays in its register while items go on

module kmer_weight_sequence_scorer #(
  parameter int MAX_K       = 8,
  parameter int LENGTH_BITS = 20
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [kws_pkg::KLEN_W-1:0]          cfg_wr_data,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                cmd,
  input  logic [kws_pkg::INDEX_W-1:0]         entry_index,
  input  logic signed [kws_pkg::WEIGHT_W-1:0] entry_weight,
  input  logic                                entry_present,
  input  logic [kws_pkg::CHAR_W-1:0]          base_char,
  input  logic                                last_base,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [kws_pkg::WEIGHT_W-1:0] mean_score,
  output logic [kws_pkg::COUNT_W-1:0]         window_count,
  output logic [kws_pkg::STATUS_W-1:0]        status
);

  import kws_pkg::*;

  localparam int AW      = 2 * MAX_K;
  localparam int DEPTH   = 1 << AW;
  localparam int SUM_W   = LENGTH_BITS + WEIGHT_W;
  localparam int DCNT_W  = $clog2(SUM_W + 1);
  localparam int IDX_EXT = AW + INDEX_W;
  localparam int CNT_EXT = LENGTH_BITS + COUNT_W;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  function automatic logic [2:0] base_code(input logic [CHAR_W-1:0] ch);
    logic [2:0] c;
    case (ch)
      CHAR_A:  c = 3'b100;
      CHAR_C:  c = 3'b101;
      CHAR_G:  c = 3'b110;
      CHAR_T:  c = 3'b111;
      default: c = 3'b000;
    endcase
    return c;
  endfunction

  state_t state, state_next;

  // table memory: {present, weight}
  logic [ENTRY_W-1:0] tbl [DEPTH];
  logic [ENTRY_W-1:0] rd_fwd, rd_rc;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  logic [AW-1:0]      clr_addr;
  logic [KLEN_W-1:0]  kmer_length;
  logic [KLEN_W-1:0]  k_eff;

  logic [AW-1:0]             kmer_history;
  logic [LENGTH_BITS-1:0]    bases_seen;
  logic signed [SUM_W-1:0]   score_sum;
  logic [STATUS_W-1:0]       error_code;

  logic s2_lookup;

  logic [DCNT_W-1:0]       div_cnt;
  logic [LENGTH_BITS:0]    div_rem;
  logic [SUM_W-1:0]        div_quo;
  logic [LENGTH_BITS-1:0]  div_den;
  logic                    div_neg;

  // fsm outputs
  logic run_open, clr_we, seq_clear, div_load, div_step, out_load_err, out_load_div;

  logic accept, base_acc, wr_acc, out_free;
  logic [2:0]             code;
  logic                   seq_active, len_ovf, bad_char, win_full, lookup;
  logic [AW-1:0]          hist_new, kmask, fwd, rc;
  logic [LENGTH_BITS-1:0] seen_new;
  logic [IDX_EXT-1:0]     idx_ext;
  logic [STATUS_W-1:0]    final_status;
  logic [LENGTH_BITS-1:0] final_count;
  logic [SUM_W-1:0]       sum_u, sum_mag;
  logic [LENGTH_BITS:0]   div_shift;
  logic                   div_ge, div_done;
  logic [SUM_W-1:0]       quo_signed;
  logic [CNT_EXT-1:0]     cnt_ext;
  logic signed [WEIGHT_W-1:0] w_sel;
  logic                   s2_hit, s2_absent;

  always_comb begin
    if (kmer_length == '0) begin
      k_eff = KLEN_W'(1);
    end else if (kmer_length > KLEN_W'(MAX_K)) begin
      k_eff = KLEN_W'(MAX_K);
    end else begin
      k_eff = kmer_length;
    end
  end

  assign out_free = !result_valid || !result_stall;
  assign accept   = item_valid && !item_stall;
  assign base_acc = accept && (cmd == CMD_BASE);
  assign wr_acc   = accept && (cmd == CMD_WRITE);

  // base front end
  assign code       = base_code(base_char);
  assign seq_active = (error_code == STATUS_OK);
  assign len_ovf    = (bases_seen == LEN_MAX);
  assign bad_char   = !code[2];
  assign hist_new   = (kmer_history << 2) | AW'(code[1:0]);
  assign seen_new   = bases_seen + 1'b1;
  assign win_full   = (seen_new >= LENGTH_BITS'(k_eff));
  assign lookup     = base_acc && seq_active && !len_ovf && !bad_char && win_full;

  always_comb begin
    kmask = '0;
    for (int b = 0; b < AW; b++) begin
      kmask[b] = (b < 2 * int'(k_eff));
    end
  end

  assign fwd = hist_new & kmask;

  // reverse complement: digit j takes the complement of digit k-1-j
  always_comb begin
    rc = '0;
    for (int j = 0; j < MAX_K; j++) begin
      for (int i = 0; i < MAX_K; i++) begin
        if (i + j + 1 == int'(k_eff)) begin
          rc[2*j +: 2] = ~fwd[2*i +: 2];
        end
      end
    end
  end

  // memory write port: clearing pass or table-load beat
  assign idx_ext = IDX_EXT'(entry_index);
  always_comb begin
    mem_we    = clr_we || wr_acc;
    mem_waddr = clr_we ? clr_addr : idx_ext[AW-1:0];
    mem_wdata = clr_we ? '0 : {entry_present, entry_weight};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (base_acc) begin
      rd_fwd <= tbl[fwd];
      rd_rc  <= tbl[rc];
    end
  end

  // lookup result stage
  always_comb begin
    s2_hit    = rd_fwd[ENTRY_W-1] || rd_rc[ENTRY_W-1];
    s2_absent = s2_lookup && seq_active && !s2_hit;
    w_sel     = rd_fwd[ENTRY_W-1] ? signed'(rd_fwd[WEIGHT_W-1:0])
                                  : signed'(rd_rc[WEIGHT_W-1:0]);
  end

  // end of sequence
  always_comb begin
    if (error_code != STATUS_OK) begin
      final_status = error_code;
    end else if (bases_seen < LENGTH_BITS'(k_eff)) begin
      final_status = STATUS_SHORT;
    end else begin
      final_status = STATUS_OK;
    end
    final_count = bases_seen - LENGTH_BITS'(k_eff) + 1'b1;
    sum_u       = score_sum;
    sum_mag     = score_sum[SUM_W-1] ? (~sum_u + 1'b1) : sum_u;
  end

  // divider step
  assign div_shift  = {div_rem[LENGTH_BITS-1:0], div_quo[SUM_W-1]};
  assign div_ge     = (div_shift >= {1'b0, div_den});
  assign div_done   = (div_cnt == DCNT_W'(SUM_W));
  assign quo_signed = div_neg ? (~div_quo + 1'b1) : div_quo;
  assign cnt_ext    = CNT_EXT'(div_den);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (&clr_addr) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (base_acc && last_base) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (final_status == STATUS_OK) begin
          state_next = ST_DIVIDE;
        end else if (out_free) begin
          state_next = ST_RUN;
        end
      end
      ST_DIVIDE: begin
        if (div_done && out_free) state_next = ST_RUN;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // fsm outputs
  always_comb begin
    run_open     = 1'b0;
    clr_we       = 1'b0;
    seq_clear    = 1'b0;
    div_load     = 1'b0;
    div_step     = 1'b0;
    out_load_err = 1'b0;
    out_load_div = 1'b0;
    case (state)
      ST_CLEAR: clr_we = 1'b1;
      ST_RUN:   run_open = 1'b1;
      ST_DRAIN: ;
      ST_FINISH: begin
        if (final_status == STATUS_OK) begin
          div_load  = 1'b1;
          seq_clear = 1'b1;
        end else if (out_free) begin
          out_load_err = 1'b1;
          seq_clear    = 1'b1;
        end
      end
      ST_DIVIDE: begin
        div_step     = !div_done;
        out_load_div = div_done && out_free;
      end
      default: ;
    endcase
  end

  assign item_stall = !run_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      kmer_length <= KLEN_RESET;
    end else begin
      state <= state_next;
      if (clr_we) clr_addr <= clr_addr + 1'b1;
      if (cfg_wr_en) kmer_length <= cfg_wr_data;
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (rst || seq_clear) begin
      kmer_history <= '0;
      bases_seen   <= '0;
      score_sum    <= '0;
      error_code   <= STATUS_OK;
      s2_lookup    <= 1'b0;
    end else begin
      s2_lookup <= lookup;
      if (base_acc && seq_active && !len_ovf && !bad_char) begin
        kmer_history <= hist_new;
        bases_seen   <= seen_new;
      end
      if (s2_lookup && seq_active && s2_hit) begin
        score_sum <= score_sum + SUM_W'(w_sel);
      end
      // the older beat's absent k-mer wins over a new base's error
      if (s2_absent) begin
        error_code <= STATUS_ABSENT;
      end else if (base_acc && seq_active && len_ovf) begin
        error_code <= STATUS_OVERFLOW;
      end else if (base_acc && seq_active && bad_char) begin
        error_code <= STATUS_BAD_BASE;
      end
    end
  end

  // shift-subtract divider on the magnitude of the sum
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (div_load) begin
      div_cnt <= '0;
    end else if (div_step) begin
      div_cnt <= div_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_load) begin
      div_rem <= '0;
      div_quo <= sum_mag;
      div_den <= final_count;
      div_neg <= score_sum[SUM_W-1];
    end else if (div_step) begin
      div_rem <= div_ge ? (div_shift - {1'b0, div_den}) : div_shift;
      div_quo <= {div_quo[SUM_W-2:0], div_ge};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load_err || out_load_div) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load_err) begin
      mean_score   <= '0;
      window_count <= '0;
      status       <= final_status;
    end else if (out_load_div) begin
      mean_score   <= signed'(quo_signed[WEIGHT_W-1:0]);
      window_count <= cnt_ext[COUNT_W-1:0];
      status       <= STATUS_OK;
    end
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

// testbench: self-checking bench for kmer_weight_sequence_scorer, table loads and base streams
// depends on kws_pkg and the scorer rtl; scores every accepted beat with its own table copy

module testbench;
  import kws_pkg::*;

  localparam int          MAX_K          = 8;
  localparam int          LENGTH_BITS    = 20;
  localparam int          TABLE_DEPTH    = 1 << (2 * MAX_K);
  localparam int unsigned SEEN_MAX       = (1 << LENGTH_BITS) - 1;
  localparam int          SETTLE_CYCLES  = 64;
  localparam int          HOLDOFF_CYCLES = 400;
  localparam int          WATCHDOG_LIMIT = 200000;
  localparam int          RANDOM_ITEMS   = 1250;

  typedef struct packed {
    logic                       cmd;
    logic [INDEX_W-1:0]         index;
    logic signed [WEIGHT_W-1:0] weight;
    logic                       present;
    logic [CHAR_W-1:0]          ch;
    logic                       last;
  } item_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] mean;
    logic [COUNT_W-1:0]         count;
    logic [STATUS_W-1:0]        status;
  } score_t;

  typedef enum int {PACE_FREE, PACE_RANDOM, PACE_HEAVY} pace_t;

  logic                       clk           = 1'b0;
  logic                       rst           = 1'b1;
  logic                       cfg_wr_en     = 1'b0;
  logic [KLEN_W-1:0]          cfg_wr_data   = '0;
  logic                       item_valid    = 1'b0;
  logic                       item_stall;
  logic                       cmd           = CMD_WRITE;
  logic [INDEX_W-1:0]         entry_index   = '0;
  logic signed [WEIGHT_W-1:0] entry_weight  = '0;
  logic                       entry_present = 1'b0;
  logic [CHAR_W-1:0]          base_char     = '0;
  logic                       last_base     = 1'b0;
  logic                       result_valid;
  logic                       result_stall  = 1'b0;
  logic signed [WEIGHT_W-1:0] mean_score;
  logic [COUNT_W-1:0]         window_count;
  logic [STATUS_W-1:0]        status;

  kmer_weight_sequence_scorer #(
    .MAX_K       (MAX_K),
    .LENGTH_BITS (LENGTH_BITS)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .cmd           (cmd),
    .entry_index   (entry_index),
    .entry_weight  (entry_weight),
    .entry_present (entry_present),
    .base_char     (base_char),
    .last_base     (last_base),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .mean_score    (mean_score),
    .window_count  (window_count),
    .status        (status)
  );

  always #2 clk = ~clk;

  // scorer copy: table, sequence state and the k register
  logic signed [WEIGHT_W-1:0] weight_mem [0:TABLE_DEPTH-1];
  bit                         present_mem [0:TABLE_DEPTH-1];
  logic [2*MAX_K-1:0]         kmer_hist  = '0;
  int unsigned                bases_in   = 0;
  longint                     weight_sum = 0;
  logic [STATUS_W-1:0]        seq_status = STATUS_OK;
  logic [KLEN_W-1:0]          kmer_len   = KLEN_RESET;

  item_t  item_backlog [$];
  score_t expected_scores [$];
  item_t  offered_beat;
  int     errors       = 0;
  int     shown        = 0;
  int     queued_items = 0;
  int     holdoff_req  = 0;

  function automatic int unsigned kmer_span(input logic [KLEN_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_K) return MAX_K;
    return v;
  endfunction

  function automatic logic [2*MAX_K-1:0] span_mask(input int unsigned span);
    logic [2*MAX_K-1:0] m;
    m = '1;
    return m >> (2 * (MAX_K - span));
  endfunction

  function automatic logic [2*MAX_K-1:0] kmer_revcomp(input logic [2*MAX_K-1:0] fwd,
                                                      input int unsigned span);
    logic [2*MAX_K-1:0] r;
    logic [2*MAX_K-1:0] c;
    r = '0;
    c = fwd;
    for (int i = 0; i < span; i++) begin
      r = {r[2*MAX_K-3:0], ~c[1:0]};
      c = c >> 2;
    end
    return r;
  endfunction

  task automatic score_item(input item_t it);
    int unsigned        span;
    int                 code;
    longint             windows;
    logic [2*MAX_K-1:0] fwd;
    logic [2*MAX_K-1:0] rev;
    score_t             s;
    span = kmer_span(kmer_len);
    if (it.cmd == CMD_WRITE) begin
      weight_mem[it.index] = it.weight;
      present_mem[it.index] = it.present;
    end else begin
      if (seq_status == STATUS_OK) begin
        case (it.ch)
          CHAR_A:  code = 0;
          CHAR_C:  code = 1;
          CHAR_G:  code = 2;
          CHAR_T:  code = 3;
          default: code = -1;
        endcase
        if (bases_in >= SEEN_MAX) begin
          seq_status = STATUS_OVERFLOW;
        end else if (code < 0) begin
          seq_status = STATUS_BAD_BASE;
        end else begin
          kmer_hist = {kmer_hist[2*MAX_K-3:0], 2'(code)};
          bases_in++;
          if (bases_in >= span) begin
            fwd = kmer_hist & span_mask(span);
            rev = kmer_revcomp(fwd, span);
            if (present_mem[fwd]) weight_sum += weight_mem[fwd];
            else if (present_mem[rev]) weight_sum += weight_mem[rev];
            else seq_status = STATUS_ABSENT;
          end
        end
      end
      if (it.last) begin
        s = '0;
        s.status = seq_status;
        if (s.status == STATUS_OK && bases_in < span) s.status = STATUS_SHORT;
        if (s.status == STATUS_OK) begin
          windows = bases_in - span + 1;
          s.count = COUNT_W'(windows);
          s.mean = WEIGHT_W'(weight_sum / windows);
        end
        expected_scores = {expected_scores, s};
        kmer_hist = '0;
        bases_in = 0;
        weight_sum = 0;
        seq_status = STATUS_OK;
      end
    end
  endtask

  task automatic queue_write(input logic [INDEX_W-1:0] idx, input logic [WEIGHT_W-1:0] w,
                             input logic p);
    item_t it;
    it.cmd = CMD_WRITE;
    it.index = idx;
    it.weight = w;
    it.present = p;
    it.ch = CHAR_W'($urandom);
    it.last = 1'($urandom);
    item_backlog = {item_backlog, it};
    queued_items++;
  endtask

  task automatic queue_base(input logic [CHAR_W-1:0] ch, input logic l);
    item_t it;
    it.cmd = CMD_BASE;
    it.index = INDEX_W'($urandom);
    it.weight = WEIGHT_W'($urandom);
    it.present = 1'($urandom);
    it.ch = ch;
    it.last = l;
    item_backlog = {item_backlog, it};
    queued_items++;
  endtask

  // loads entries for most windows of a random sequence first, so that most sequences score
  task automatic queue_scored_sequence(input int unsigned span);
    logic [1:0]         codes [$];
    logic [2*MAX_K-1:0] window;
    logic [CHAR_W-1:0]  ch;
    int unsigned        len;
    window = '0;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, span)
                                      : $urandom_range(span, span + 12);
    for (int i = 0; i < len; i++) begin
      codes = {codes, 2'($urandom_range(0, 3))};
      window = {window[2*MAX_K-3:0], codes[i]};
      if (i + 1 >= span && $urandom_range(0, 24) != 0) begin
        if ($urandom_range(0, 1))
          queue_write(window & span_mask(span), WEIGHT_W'($urandom),
                      $urandom_range(0, 19) != 0);
        else
          queue_write(kmer_revcomp(window & span_mask(span), span), WEIGHT_W'($urandom),
                      $urandom_range(0, 19) != 0);
      end
    end
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0)
        queue_write(INDEX_W'($urandom), WEIGHT_W'($urandom), 1'($urandom));
      case (codes[i])
        2'd0:    ch = CHAR_A;
        2'd1:    ch = CHAR_C;
        2'd2:    ch = CHAR_G;
        default: ch = CHAR_T;
      endcase
      if ($urandom_range(0, 39) == 0) ch = CHAR_W'($urandom);
      queue_base(ch, i == len - 1);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (item_backlog.size() != 0 || item_valid || expected_scores.size() != 0)
      @(negedge clk);
    // a table write or a plain base leaves no result to wait for
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_kmer_length(input logic [KLEN_W-1:0] v);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    kmer_len = v;
    @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input score_t want, input score_t got);
    errors++;
    if (shown < 10) begin
      shown++;
      $display("%s: expected mean %0d count %0d status %0d, got mean %0d count %0d status %0d",
               what, want.mean, want.count, want.status, got.mean, got.count, got.status);
    end
  endtask

  // sender: bursts of random length, random gaps, payload held while stalled
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_items
    item_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) score_item(offered_beat);
      if (!item_valid || !item_stall) begin
        if (gap_left != 0) begin
          item_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (item_backlog.size() != 0) begin
          nxt = item_backlog.pop_front();
          offered_beat <= nxt;
          cmd <= nxt.cmd;
          entry_index <= nxt.index;
          entry_weight <= nxt.weight;
          entry_present <= nxt.present;
          base_char <= nxt.ch;
          last_base <= nxt.last;
          item_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern changes every so often, plus a long hold-off on request
  int    holdoff_seen = 0;
  int    holdoff_left = 0;
  int    mode_left    = 0;
  pace_t stall_mode   = PACE_FREE;

  always @(posedge clk) begin : pace_results
    if (rst) begin
      result_stall <= 1'b0;
    end else if (holdoff_left != 0) begin
      result_stall <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_seen != holdoff_req) begin
      holdoff_seen <= holdoff_req;
      holdoff_left <= HOLDOFF_CYCLES;
      result_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= pace_t'($urandom_range(0, 2));
        mode_left <= $urandom_range(16, 160);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        PACE_FREE:   result_stall <= 1'b0;
        PACE_RANDOM: result_stall <= 1'($urandom_range(0, 1));
        default:     result_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    score_t want;
    score_t got;
    if (!rst && result_valid && !result_stall) begin
      got.mean = mean_score;
      got.count = window_count;
      got.status = status;
      if (expected_scores.size() == 0) begin
        report_mismatch("result beat with no score pending", '0, got);
      end else begin
        want = expected_scores.pop_front();
        if (got.mean !== want.mean || got.count !== want.count || got.status !== want.status)
          report_mismatch("score mismatch", want, got);
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[kmer_weight_sequence_scorer] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned       span;
    int                phase;
    logic [KLEN_W-1:0] kv;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // k = 8 from reset: index and weight extremes, errors, reverse complement hit
    queue_write(16'hFFFF, 16'h7FFF, 1'b1);
    queue_write(16'h0000, 16'h8000, 1'b1);
    queue_write(16'h5555, 16'h0123, 1'b0);
    queue_write(16'hAAAA, 16'hFFF9, 1'b1);
    queue_base(8'h00, 1'b0);
    queue_base(CHAR_A, 1'b0);
    queue_base(8'hFF, 1'b1);
    queue_base(CHAR_T, 1'b1);
    repeat (4) queue_base(CHAR_C, 1'b0);
    queue_write(16'h1234, 16'h4321, 1'b0);
    repeat (3) queue_base(CHAR_C, 1'b0);
    queue_base(CHAR_C, 1'b1);

    // k = 1: max plus min truncates to zero, absent both ways, complement hit
    set_kmer_length(4'd1);
    queue_write(16'h0003, 16'h7FFF, 1'b1);
    queue_base(CHAR_T, 1'b0);
    queue_base(CHAR_A, 1'b1);
    queue_base(CHAR_G, 1'b1);
    queue_write(16'h0001, 16'h0005, 1'b1);
    queue_base(CHAR_G, 1'b1);

    // k changes in the middle of a sequence
    set_kmer_length(4'd2);
    queue_base(CHAR_A, 1'b0);
    set_kmer_length(4'd3);
    queue_base(CHAR_A, 1'b0);
    queue_base(CHAR_A, 1'b1);

    // receiver holds off while short sequences keep coming, so the input backs up
    set_kmer_length(4'd2);
    holdoff_req++;
    repeat (16) queue_scored_sequence(2);

    phase = 0;
    while (queued_items < RANDOM_ITEMS) begin
      if (phase == 0)
        kv = 4'(MAX_K);
      else if ($urandom_range(0, 7) == 0)
        kv = $urandom_range(0, 1) ? 4'd15 : 4'd0;
      else
        kv = 4'($urandom_range(1, MAX_K));
      phase++;
      set_kmer_length(kv);
      span = kmer_span(kv);
      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1))
              queue_write(INDEX_W'($urandom), WEIGHT_W'($urandom), 1'($urandom));
            else
              queue_base(CHAR_W'($urandom), $urandom_range(0, 3) == 0);
          end
        end
        queue_scored_sequence(span);
      end
    end

    wait_idle();
    if (errors == 0 && expected_scores.size() == 0)
      $display("[kmer_weight_sequence_scorer] OK");
    else
      $display("[kmer_weight_sequence_scorer] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
design/kws_pkg.sv
design/kmer_weight_sequence_scorer.sv
test/testbench.sv
